// ===== hdl/avps_pkg.sv =====
// Package for the animated Voronoi pixel shader: widths, hash constants,
// register indexes and the small helper functions shared by the design.
// No dependencies.
`default_nettype none

package avps_pkg;

	localparam int GRID_CELLS_DEF = 8;

	localparam int COORD_W = 17;
	localparam int PHASE_W = 20;
	localparam int COLOR_W = 24;
	localparam int CFG_IDX_W = 8;
	localparam int CIDX_W = 9;
	localparam int POS_W = 20;
	localparam int D2_W = 36;
	localparam int ROOT_W = 18;
	localparam int REM_W = ROOT_W + 3;
	localparam int NUM_NEIGH = 9;
	localparam int NUM_THEMES = 4;

	localparam logic [PHASE_W-1:0] PHASE_CYCLE = 20'd1000000;
	// floor(2^20 * 65536 / 1000000); the estimate is at most one below the true quotient.
	localparam logic [16:0] T_RECIP = 17'd68719;

	localparam logic [31:0] HASH_MX = 32'd374761393;
	localparam logic [31:0] HASH_MY = 32'd668265263;
	localparam logic [31:0] HASH_MT = 32'd2246822519;
	localparam logic [31:0] HASH_MF = 32'd1274126177;

	localparam logic [CFG_IDX_W-1:0] REG_THEME_ZERO = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THEME_ONE = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THEME_TWO = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THEME_THREE = 8'd3;

	typedef struct packed {
		logic [D2_W-1:0] d2;
		logic [3:0] idx;
	} cand_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} sqrt_st_t;

	// On equal distances the earlier candidate in scan order is kept.
	function automatic cand_t cand_min(cand_t a, cand_t b);
		return (b.d2 < a.d2) ? b : a;
	endfunction

	// One digit of the restoring integer square root.
	function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [1:0] pair);
		logic [REM_W-1:0] acc;
		logic [REM_W-1:0] trial;
		sqrt_st_t r;
		acc = {s.rem[REM_W-3:0], pair};
		trial = {1'b0, s.root, 2'b01};
		if (acc >= trial) begin
			r.rem = acc - trial;
			r.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem = acc;
			r.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/avps_if.sv =====
// Channel interfaces of the animated Voronoi pixel shader: pixel input,
// color output and configuration write. Depends on avps_pkg.
`default_nettype none

interface avps_pix_if;
	logic valid;
	logic ready;
	logic [avps_pkg::COORD_W-1:0] coord_u;
	logic [avps_pkg::COORD_W-1:0] coord_v;
	logic [avps_pkg::PHASE_W-1:0] anim_phase;
	modport source(output valid, coord_u, coord_v, anim_phase, input ready);
	modport sink(input valid, coord_u, coord_v, anim_phase, output ready);
endinterface

interface avps_rgb_if;
	logic valid;
	logic ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic [1:0] palette_pick;
	modport source(output valid, red_out, green_out, blue_out, palette_pick, input ready);
	modport sink(input valid, red_out, green_out, blue_out, palette_pick, output ready);
endinterface

interface avps_cfg_if;
	logic valid;
	logic ready;
	logic [avps_pkg::CFG_IDX_W-1:0] index;
	logic [avps_pkg::COLOR_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/animated_voronoi_pixel_shader.sv =====
// Top level of the animated Voronoi pixel shader, a 26-stage pipeline.
// Depends on avps_pkg and the interfaces in avps_if.sv.
`default_nettype none

// One pixel enters per clock while pix.ready is high. The stages cover cell
// division, hash multiplies, jitter and wobble, squared distances, a
// four-level minimum tree, nine two-digit stages of the square root, the
// falloff divide and the channel scaling. All stages advance together,
// so pix.ready drops only while a finished color sits unread on rgb.
// Palette writes on cfg are always taken; indexes above three are ignored.
module animated_voronoi_pixel_shader #(
	parameter int GRID_CELLS = avps_pkg::GRID_CELLS_DEF
) (
	input logic clk,
	input logic arst_n,
	avps_pix_if.sink pix,
	avps_cfg_if.sink cfg,
	avps_rgb_if.source rgb
);

	localparam int CELL = 65536 / GRID_CELLS;
	localparam int AMP = CELL / 4;
	localparam int FALL = CELL * 3 / 2;
	localparam logic [31:0] MDIV = 32'((64'd1 << 32) / CELL);
	localparam logic [31:0] MFALL = 32'((64'd1 << 32) / FALL);
	localparam int NST = 26;
	localparam int NSQ = avps_pkg::ROOT_W / 2;

	localparam int CW = avps_pkg::CIDX_W;
	localparam int PW = avps_pkg::POS_W;
	localparam int DW = avps_pkg::D2_W;
	localparam int NN = avps_pkg::NUM_NEIGH;

	logic en;
	logic [NST:1] vld_s;
	logic [avps_pkg::COLOR_W-1:0] theme_q [avps_pkg::NUM_THEMES];

	assign en = !vld_s[NST] || rgb.ready;
	assign pix.ready = en;
	assign cfg.ready = 1'b1;
	assign rgb.valid = vld_s[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-1:1], pix.valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < avps_pkg::NUM_THEMES; i++) theme_q[i] <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				avps_pkg::REG_THEME_ZERO: theme_q[0] <= cfg.data;
				avps_pkg::REG_THEME_ONE: theme_q[1] <= cfg.data;
				avps_pkg::REG_THEME_TWO: theme_q[2] <= cfg.data;
				avps_pkg::REG_THEME_THREE: theme_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	// Stage 1: clamp the phase, estimate the cell index and the phase scale.
	logic [16:0] fx_s1, fy_s1;
	logic [19:0] pc_s1;
	logic [CW-1:0] qx_s1, qy_s1;
	logic [16:0] tq_s1;
	logic [19:0] pc_c;

	assign pc_c = (pix.anim_phase > avps_pkg::PHASE_CYCLE) ? avps_pkg::PHASE_CYCLE
		: pix.anim_phase;

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s1 <= pix.coord_u;
			fy_s1 <= pix.coord_v;
			pc_s1 <= pc_c;
			qx_s1 <= CW'((49'(pix.coord_u) * 49'(MDIV)) >> 32);
			qy_s1 <= CW'((49'(pix.coord_v) * 49'(MDIV)) >> 32);
			tq_s1 <= 17'((37'(pc_c) * 37'(avps_pkg::T_RECIP)) >> 20);
		end
	end

	// Stage 2: correct the estimates by one where the remainder overshoots.
	logic [16:0] fx_s2, fy_s2;
	logic [CW-1:0] cellx_s2, celly_s2;
	logic [16:0] t_s2;
	logic [31:0] rx_c, ry_c;
	logic [36:0] rt_c;

	assign rx_c = 32'(fx_s1) - 32'(qx_s1) * 32'(CELL);
	assign ry_c = 32'(fy_s1) - 32'(qy_s1) * 32'(CELL);
	assign rt_c = {1'b0, pc_s1, 16'h0000} - 37'(tq_s1) * 37'(avps_pkg::PHASE_CYCLE);

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s2 <= fx_s1;
			fy_s2 <= fy_s1;
			cellx_s2 <= (rx_c >= 32'(CELL)) ? qx_s1 + CW'(1) : qx_s1;
			celly_s2 <= (ry_c >= 32'(CELL)) ? qy_s1 + CW'(1) : qy_s1;
			t_s2 <= (rt_c >= 37'(avps_pkg::PHASE_CYCLE)) ? tq_s1 + 17'd1 : tq_s1;
		end
	end

	// Stage 3: per-row and per-column hash products and cell corners.
	logic [16:0] fx_s3, fy_s3;
	logic [16:0] t_s3;
	logic [31:0] pa_s3 [3];
	logic [31:0] pb_s3 [3];
	logic signed [PW-1:0] bx_s3 [3];
	logic signed [PW-1:0] by_s3 [3];

	always_ff @(posedge clk) begin
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		if (en) begin
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
			t_s3 <= t_s2;
			for (int i = 0; i < 3; i++) begin
				cx = $signed(cellx_s2) + CW'(i - 1);
				cy = $signed(celly_s2) + CW'(i - 1);
				pa_s3[i] <= 32'(cx) * avps_pkg::HASH_MX;
				pb_s3[i] <= 32'(cy) * avps_pkg::HASH_MY;
				bx_s3[i] <= PW'(cx) * $signed(PW'(CELL));
				by_s3[i] <= PW'(cy) * $signed(PW'(CELL));
			end
		end
	end

	// Stage 4: combine into the three tagged hashes of each of the nine cells.
	logic [16:0] fx_s4, fy_s4;
	logic [16:0] t_s4;
	logic signed [PW-1:0] bx_s4 [3];
	logic signed [PW-1:0] by_s4 [3];
	logic [31:0] hm_s4 [NN][3];

	always_ff @(posedge clk) begin
		logic [31:0] h0;
		if (en) begin
			fx_s4 <= fx_s3;
			fy_s4 <= fy_s3;
			t_s4 <= t_s3;
			bx_s4 <= bx_s3;
			by_s4 <= by_s3;
			for (int k = 0; k < NN; k++) begin
				for (int j = 0; j < 3; j++) begin
					h0 = pa_s3[k % 3] + pb_s3[k / 3] + 32'(32'(j + 1) * avps_pkg::HASH_MT);
					hm_s4[k][j] <= h0 ^ (h0 >> 13);
				end
			end
		end
	end

	// Stage 5: final hash multiply.
	logic [16:0] fx_s5, fy_s5;
	logic [16:0] t_s5;
	logic signed [PW-1:0] bx_s5 [3];
	logic signed [PW-1:0] by_s5 [3];
	logic [31:0] hp_s5 [NN][3];

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s5 <= fx_s4;
			fy_s5 <= fy_s4;
			t_s5 <= t_s4;
			bx_s5 <= bx_s4;
			by_s5 <= by_s4;
			for (int k = 0; k < NN; k++) begin
				for (int j = 0; j < 3; j++) hp_s5[k][j] <= hm_s4[k][j] * avps_pkg::HASH_MF;
			end
		end
	end

	// Stage 6: last fold of the hashes; the third tag gives the palette index.
	logic [16:0] fx_s6, fy_s6;
	logic [16:0] t_s6;
	logic signed [PW-1:0] bx_s6 [3];
	logic signed [PW-1:0] by_s6 [3];
	logic [31:0] hx_s6 [NN];
	logic [31:0] hy_s6 [NN];
	logic [1:0] pk_s6 [NN];

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s6 <= fx_s5;
			fy_s6 <= fy_s5;
			t_s6 <= t_s5;
			bx_s6 <= bx_s5;
			by_s6 <= by_s5;
			for (int k = 0; k < NN; k++) begin
				hx_s6[k] <= hp_s5[k][0] ^ (hp_s5[k][0] >> 16);
				hy_s6[k] <= hp_s5[k][1] ^ (hp_s5[k][1] >> 16);
				pk_s6[k] <= 2'(hp_s5[k][2] ^ (hp_s5[k][2] >> 16));
			end
		end
	end

	// Stage 7: quotient estimate for the jitter and the triangle wave.
	logic [16:0] fx_s7, fy_s7;
	logic signed [PW-1:0] bx_s7 [3];
	logic signed [PW-1:0] by_s7 [3];
	logic [1:0] pk_s7 [NN];
	logic [31:0] hx_s7 [NN];
	logic [31:0] hy_s7 [NN];
	logic [31:0] qhx_s7 [NN];
	logic [31:0] qhy_s7 [NN];
	logic [16:0] trx_s7 [NN];
	logic [16:0] try_s7 [NN];

	always_ff @(posedge clk) begin
		logic [15:0] px;
		logic [15:0] py;
		if (en) begin
			fx_s7 <= fx_s6;
			fy_s7 <= fy_s6;
			bx_s7 <= bx_s6;
			by_s7 <= by_s6;
			pk_s7 <= pk_s6;
			hx_s7 <= hx_s6;
			hy_s7 <= hy_s6;
			for (int k = 0; k < NN; k++) begin
				qhx_s7[k] <= 32'((64'(hx_s6[k]) * 64'(MDIV)) >> 32);
				qhy_s7[k] <= 32'((64'(hy_s6[k]) * 64'(MDIV)) >> 32);
				px = t_s6[15:0] + hx_s6[k][15:0];
				py = t_s6[15:0] + hy_s6[k][15:0];
				trx_s7[k] <= px[15] ? 17'h10000 - 17'(px) : 17'(px);
				try_s7[k] <= py[15] ? 17'h10000 - 17'(py) : 17'(py);
			end
		end
	end

	// Stage 8: jitter remainder and wobble product.
	logic [16:0] fx_s8, fy_s8;
	logic signed [PW-1:0] bx_s8 [3];
	logic signed [PW-1:0] by_s8 [3];
	logic [1:0] pk_s8 [NN];
	logic [15:0] jx_s8 [NN];
	logic [15:0] jy_s8 [NN];
	logic [30:0] wx_s8 [NN];
	logic [30:0] wy_s8 [NN];

	always_ff @(posedge clk) begin
		logic [31:0] rx;
		logic [31:0] ry;
		if (en) begin
			fx_s8 <= fx_s7;
			fy_s8 <= fy_s7;
			bx_s8 <= bx_s7;
			by_s8 <= by_s7;
			pk_s8 <= pk_s7;
			for (int k = 0; k < NN; k++) begin
				rx = hx_s7[k] - qhx_s7[k] * 32'(CELL);
				ry = hy_s7[k] - qhy_s7[k] * 32'(CELL);
				jx_s8[k] <= 16'((rx >= 32'(CELL)) ? rx - 32'(CELL) : rx);
				jy_s8[k] <= 16'((ry >= 32'(CELL)) ? ry - 32'(CELL) : ry);
				wx_s8[k] <= 31'(trx_s7[k]) * 31'(AMP);
				wy_s8[k] <= 31'(try_s7[k]) * 31'(AMP);
			end
		end
	end

	// Stage 9: feature point and absolute offsets from the pixel.
	logic [1:0] pk_s9 [NN];
	logic [16:0] ax_s9 [NN];
	logic [16:0] ay_s9 [NN];

	always_ff @(posedge clk) begin
		logic signed [PW-1:0] ptx;
		logic signed [PW-1:0] pty;
		logic signed [PW-1:0] ex;
		logic signed [PW-1:0] ey;
		if (en) begin
			pk_s9 <= pk_s8;
			for (int k = 0; k < NN; k++) begin
				ptx = bx_s8[k % 3] + $signed(PW'(jx_s8[k])) + $signed(PW'(wx_s8[k] >> 14))
					- $signed(PW'(AMP));
				pty = by_s8[k / 3] + $signed(PW'(jy_s8[k])) + $signed(PW'(wy_s8[k] >> 14))
					- $signed(PW'(AMP));
				ex = $signed(PW'(fx_s8)) - ptx;
				ey = $signed(PW'(fy_s8)) - pty;
				ax_s9[k] <= 17'(ex[PW-1] ? -ex : ex);
				ay_s9[k] <= 17'(ey[PW-1] ? -ey : ey);
			end
		end
	end

	// Stage 10: squared distances.
	logic [1:0] pk_s10 [NN];
	avps_pkg::cand_t cd_s10 [NN];

	always_ff @(posedge clk) begin
		if (en) begin
			pk_s10 <= pk_s9;
			for (int k = 0; k < NN; k++) begin
				cd_s10[k].d2 <= DW'(ax_s9[k]) * DW'(ax_s9[k]) + DW'(ay_s9[k]) * DW'(ay_s9[k]);
				cd_s10[k].idx <= 4'(k);
			end
		end
	end

	// Stages 11 to 14: minimum tree in scan order.
	logic [1:0] pk_s11 [NN];
	logic [1:0] pk_s12 [NN];
	logic [1:0] pk_s13 [NN];
	avps_pkg::cand_t cd_s11 [5];
	avps_pkg::cand_t cd_s12 [3];
	avps_pkg::cand_t cd_s13 [2];
	logic [DW-1:0] best_s14;
	logic [1:0] pick_s14;
	avps_pkg::cand_t win_c;

	assign win_c = avps_pkg::cand_min(cd_s13[0], cd_s13[1]);

	always_ff @(posedge clk) begin
		if (en) begin
			pk_s11 <= pk_s10;
			for (int i = 0; i < 4; i++)
				cd_s11[i] <= avps_pkg::cand_min(cd_s10[2*i], cd_s10[2*i+1]);
			cd_s11[4] <= cd_s10[8];
			pk_s12 <= pk_s11;
			cd_s12[0] <= avps_pkg::cand_min(cd_s11[0], cd_s11[1]);
			cd_s12[1] <= avps_pkg::cand_min(cd_s11[2], cd_s11[3]);
			cd_s12[2] <= cd_s11[4];
			pk_s13 <= pk_s12;
			cd_s13[0] <= avps_pkg::cand_min(cd_s12[0], cd_s12[1]);
			cd_s13[1] <= cd_s12[2];
			best_s14 <= win_c.d2;
			pick_s14 <= pk_s13[win_c.idx];
		end
	end

	// Stages 15 to 23: square root, two digits per stage.
	avps_pkg::sqrt_st_t sq_s [1:NSQ];
	logic [DW-1:0] sn_s [1:NSQ];
	logic [1:0] sp_s [1:NSQ];

	for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
		avps_pkg::sqrt_st_t st_in;
		logic [DW-1:0] n_in;
		logic [1:0] p_in;
		if (g == 0) begin : g_first
			assign st_in = '0;
			assign n_in = best_s14;
			assign p_in = pick_s14;
		end else begin : g_next
			assign st_in = sq_s[g];
			assign n_in = sn_s[g];
			assign p_in = sp_s[g];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[g+1] <= avps_pkg::sqrt_step(
					avps_pkg::sqrt_step(st_in, n_in[DW-1-4*g -: 2]),
					n_in[DW-3-4*g -: 2]);
				sn_s[g+1] <= n_in;
				sp_s[g+1] <= p_in;
			end
		end
	end

	// Stage 24: clamp the distance to the falloff span and estimate the scale.
	logic [15:0] dc_s24;
	logic [16:0] fq_s24;
	logic [1:0] pick_s24;
	logic [15:0] dc_c;

	assign dc_c = (sq_s[NSQ].root > avps_pkg::ROOT_W'(FALL)) ? 16'(FALL)
		: 16'(sq_s[NSQ].root);

	always_ff @(posedge clk) begin
		if (en) begin
			dc_s24 <= dc_c;
			fq_s24 <= 17'((48'(dc_c) * 48'(MFALL)) >> 16);
			pick_s24 <= sp_s[NSQ];
		end
	end

	// Stage 25: correct the scale, clamp to one half and form the glow.
	logic [16:0] glow_s25;
	logic [1:0] pick_s25;
	logic [avps_pkg::COLOR_W-1:0] col_s25;
	logic [32:0] rf_c;
	logic [16:0] sc_c;

	assign rf_c = {1'b0, dc_s24, 16'h0000} - 33'(fq_s24) * 33'(FALL);
	assign sc_c = (rf_c >= 33'(FALL)) ? fq_s24 + 17'd1 : fq_s24;

	always_ff @(posedge clk) begin
		if (en) begin
			glow_s25 <= 17'h10000 - ((sc_c > 17'h08000) ? 17'h08000 : sc_c);
			pick_s25 <= pick_s24;
			col_s25 <= theme_q[pick_s24];
		end
	end

	// Stage 26: channel scaling into the output register.
	logic [7:0] red_s26, green_s26, blue_s26;
	logic [1:0] pick_s26;

	always_ff @(posedge clk) begin
		if (en) begin
			red_s26 <= 8'((25'(col_s25[23:16]) * 25'(glow_s25)) >> 16);
			green_s26 <= 8'((25'(col_s25[15:8]) * 25'(glow_s25)) >> 16);
			blue_s26 <= 8'((25'(col_s25[7:0]) * 25'(glow_s25)) >> 16);
			pick_s26 <= pick_s25;
		end
	end

	assign rgb.red_out = red_s26;
	assign rgb.green_out = green_s26;
	assign rgb.blue_out = blue_s26;
	assign rgb.palette_pick = pick_s26;

endmodule

`default_nettype wire
